// File: rtl/weight_window_roulette_split_macros.svh
// Assertion macros for the block that checks its own behavior.
`ifndef WEIGHT_WINDOW_ROULETTE_SPLIT_MACROS_SVH
`define WEIGHT_WINDOW_ROULETTE_SPLIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define WWRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("weight window check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define WWRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("weight window check failed");

`endif

// File: rtl/wwrs_pkg.sv
package wwrs_pkg;

    localparam int DefMaxSplit = 64;

    localparam logic [2:0] OC_IN_WINDOW = 3'd0;
    localparam logic [2:0] OC_SURVIVED  = 3'd1;
    localparam logic [2:0] OC_KILLED    = 3'd2;
    localparam logic [2:0] OC_SPLIT     = 3'd3;
    localparam logic [2:0] OC_BAD       = 3'd4;

    typedef struct packed {
        logic [31:0] particle_weight;
        logic [31:0] lower_bound;
        logic [31:0] upper_bound;
        logic [31:0] target_weight;
        logic [15:0] random_value;
    } t_in;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [31:0] copy_weight;
        logic [6:0]  split_count;
        logic        split_saturated;
    } t_out;

endpackage

// File: rtl/wwrs_in_if.sv
interface wwrs_in_if
    import wwrs_pkg::*;
;
    logic valid;
    logic ready;
    t_in  data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: rtl/wwrs_out_if.sv
interface wwrs_out_if
    import wwrs_pkg::*;
;
    logic valid;
    logic ready;
    t_out data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: rtl/wwrs_div.sv
// Restoring divider, one quotient bit per pipeline stage. The quotient must fit in QW bits.
module wwrs_div
    import wwrs_pkg::*;
#(
    parameter int  DW = 32,
    parameter int  VW = 32,
    parameter int  QW = 8,
    parameter type t_side = logic
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  t_side         i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output t_side         o_side
);
    localparam int SW = (DW > VW + QW) ? DW : VW + QW;

    logic [QW-1:0] r_valid;
    logic [SW-1:0] r_rem [QW];
    logic [SW-1:0] r_dvs [QW];
    logic [QW-1:0] r_q   [QW];
    t_side         r_side[QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic          v_in;
        logic [SW-1:0] rem_in;
        logic [SW-1:0] dvs_in;
        logic [QW-1:0] q_in;
        t_side         side_in;
        logic [SW-1:0] sh;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = SW'(i_dividend);
            assign dvs_in  = SW'(i_divisor);
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[j-1];
            assign rem_in  = r_rem[j-1];
            assign dvs_in  = r_dvs[j-1];
            assign q_in    = r_q[j-1];
            assign side_in = r_side[j-1];
        end

        assign sh = dvs_in << (QW - 1 - j);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvs[j]  <= dvs_in;
                r_side[j] <= side_in;
                if (rem_in >= sh) begin
                    r_rem[j] <= rem_in - sh;
                    r_q[j]   <= q_in | (QW'(1) << (QW - 1 - j));
                end else begin
                    r_rem[j] <= rem_in;
                    r_q[j]   <= q_in;
                end
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_side  = r_side[QW-1];
endmodule

// File: rtl/weight_window_roulette_split.sv
// Weight-window roulette and splitting for a stream of particle events. One event is accepted
// every cycle while the result side keeps up. The pipeline runs through two restoring dividers
// that retire one quotient bit per stage: QB stages, where QB is clog2(MAX_SPLIT), find the
// split count and 32 stages divide the weight by it, after two stages of window tests and
// multiplies and before one output register. A stall on the result side holds the whole
// pipeline in place.
module weight_window_roulette_split
    import wwrs_pkg::*;
#(
    parameter int MAX_SPLIT = DefMaxSplit
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wwrs_in_if.sink    i_in,
    wwrs_out_if.source o_out
);
    `include "weight_window_roulette_split_macros.svh"

    localparam int QB = (MAX_SPLIT > 1) ? $clog2(MAX_SPLIT) : 1;
    localparam int NW = $clog2(MAX_SPLIT + 1);

    typedef struct packed {
        logic [2:0]  code;
        logic        sat;
        logic [31:0] w;
        logic [31:0] tgt;
    } t_cside;

    typedef struct packed {
        logic [2:0]    code;
        logic          sat;
        logic [NW-1:0] n;
        logic [31:0]   w;
        logic [31:0]   tgt;
    } t_wside;

    logic en;
    logic r_out_valid;
    t_out r_out;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // First stage: window tests and the two products.
    logic             r1_valid;
    logic [31:0]      r1_w, r1_tgt, r1_up;
    logic             r1_bad, r1_low, r1_high;
    logic [47:0]      r1_prod;
    logic [32+NW-1:0] r1_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_w    <= i_in.data.particle_weight;
            r1_tgt  <= i_in.data.target_weight;
            r1_up   <= i_in.data.upper_bound;
            r1_bad  <= (i_in.data.upper_bound == 32'd0);
            r1_low  <= (i_in.data.particle_weight < i_in.data.lower_bound);
            r1_high <= (i_in.data.particle_weight > i_in.data.upper_bound);
            r1_prod <= 48'(i_in.data.random_value) * 48'(i_in.data.lower_bound);
            r1_lim  <= (32 + NW)'(i_in.data.upper_bound) * (32 + NW)'(MAX_SPLIT);
        end
    end

    // Second stage: outcome decision. Saturation when (w - 1) / up reaches MAX_SPLIT.
    logic        r2_valid;
    logic [2:0]  r2_code;
    logic        r2_sat;
    logic [31:0] r2_w, r2_tgt, r2_up;
    logic [2:0]  n2_code;

    always_comb begin
        if (r1_bad) begin
            n2_code = OC_BAD;
        end else if (r1_low) begin
            n2_code = (r1_prod < {r1_w, 16'h0000}) ? OC_SURVIVED : OC_KILLED;
        end else if (r1_high) begin
            n2_code = OC_SPLIT;
        end else begin
            n2_code = OC_IN_WINDOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_code <= n2_code;
            r2_sat  <= (n2_code == OC_SPLIT) && ((32 + NW)'(r1_w - 32'd1) >= r1_lim);
            r2_w    <= r1_w;
            r2_tgt  <= r1_tgt;
            r2_up   <= r1_up;
        end
    end

    // Split count: ceil(w / up) = (w - 1) / up + 1, quotient below MAX_SPLIT when not saturated.
    t_cside         c_side_in, c_side_out;
    logic           c_valid;
    logic [QB-1:0]  c_quot;

    assign c_side_in = '{code: r2_code, sat: r2_sat, w: r2_w, tgt: r2_tgt};

    wwrs_div #(.DW(32), .VW(32), .QW(QB), .t_side(t_cside)) u_count_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r2_valid),
        .i_dividend (r2_w - 32'd1),
        .i_divisor  (r2_up),
        .i_side     (c_side_in),
        .o_valid    (c_valid),
        .o_quot     (c_quot),
        .o_side     (c_side_out)
    );

    logic [NW-1:0] c_n;
    t_wside        w_side_in, w_side_out;
    logic          w_valid;
    logic [31:0]   w_quot;

    assign c_n = c_side_out.sat ? NW'(MAX_SPLIT) : NW'(c_quot) + NW'(1);
    assign w_side_in = '{code: c_side_out.code, sat: c_side_out.sat, n: c_n,
                         w: c_side_out.w, tgt: c_side_out.tgt};

    wwrs_div #(.DW(32), .VW(NW), .QW(32), .t_side(t_wside)) u_weight_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (c_valid),
        .i_dividend (c_side_out.w),
        .i_divisor  (c_n),
        .i_side     (w_side_in),
        .o_valid    (w_valid),
        .o_quot     (w_quot),
        .o_side     (w_side_out)
    );

    t_out n_out;

    always_comb begin
        n_out = '{outcome: w_side_out.code, copy_weight: w_side_out.w,
                  split_count: 7'd1, split_saturated: 1'b0};
        case (w_side_out.code)
            OC_SURVIVED: n_out.copy_weight = w_side_out.tgt;
            OC_KILLED:   n_out.copy_weight = 32'd0;
            OC_SPLIT: begin
                n_out.copy_weight     = w_quot;
                n_out.split_count     = 7'(w_side_out.n);
                n_out.split_saturated = w_side_out.sat;
            end
            default:     n_out.copy_weight = w_side_out.w;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `WWRS_ASSERT_IMP(a_stall_only_when_held, !i_in.ready, o_out.valid)
    `WWRS_ASSERT_IMP(a_plain_count, o_out.valid && o_out.data.outcome != OC_SPLIT,
        o_out.data.split_count == 7'd1 && !o_out.data.split_saturated)
    `WWRS_ASSERT_IMP(a_killed_zero, o_out.valid && o_out.data.outcome == OC_KILLED,
        o_out.data.copy_weight == 32'd0)
    `WWRS_ASSERT_NEXT(a_hold_on_stall, o_out.valid && !o_out.ready,
        o_out.valid && $stable(r_out) && $stable(w_valid))
endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import wwrs_pkg::*;
;

    localparam int MaxSplit = DefMaxSplit;
    localparam int Latency = 50;
    localparam int WatchdogLimit = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wwrs_in_if  in_ch();
    wwrs_out_if out_ch();

    weight_window_roulette_split #(.MAX_SPLIT(MaxSplit)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    t_out expected_results[$];
    int   error_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   idle_cycles = 0;

    function automatic t_out predict_window(t_in ev);
        t_out r;
        logic [47:0] product;
        logic [47:0] scaled;
        logic [32:0] copies;
        r.outcome = OC_IN_WINDOW;
        r.copy_weight = ev.particle_weight;
        r.split_count = 7'd1;
        r.split_saturated = 1'b0;
        if (ev.upper_bound == 32'd0) begin
            r.outcome = OC_BAD;
        end else if (ev.particle_weight < ev.lower_bound) begin
            product = 48'(ev.random_value) * 48'(ev.lower_bound);
            scaled = {ev.particle_weight, 16'd0};
            if (product < scaled) begin
                r.outcome = OC_SURVIVED;
                r.copy_weight = ev.target_weight;
            end else begin
                r.outcome = OC_KILLED;
                r.copy_weight = 32'd0;
            end
        end else if (ev.particle_weight > ev.upper_bound) begin
            copies = 33'((64'(ev.particle_weight) + 64'(ev.upper_bound) - 64'd1)
                         / 64'(ev.upper_bound));
            if (copies > 33'(MaxSplit)) begin
                copies = 33'(MaxSplit);
                r.split_saturated = 1'b1;
            end
            r.outcome = OC_SPLIT;
            r.copy_weight = 32'(64'(ev.particle_weight) / 64'(copies));
            r.split_count = 7'(copies);
        end
        return r;
    endfunction

    // Receiver: ready toggles at random, each transaction checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, out_ch.data);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== out_ch.data) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want,
                                 out_ch.data);
                        error_count <= error_count + 1;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end else begin
            out_ch.ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_event(t_in ev);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= ev;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results.insert(expected_results.size(), predict_window(ev));
    endtask

    // Drops valid after the last transaction of a test.
    task automatic idle_input();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(255));
            2: return 32'hFFFF_FFFF - 32'($urandom_range(255));
            default: return 32'($urandom_range(32'h0010_0000));
        endcase
    endfunction

    function automatic t_in rand_event();
        t_in ev;
        logic [31:0] center;
        ev.random_value = 16'($urandom);
        ev.target_weight = $urandom;
        center = rand_weight();
        ev.lower_bound = center >> $urandom_range(4);
        ev.upper_bound = center;
        if ($urandom_range(9) == 0) ev.upper_bound = 32'd0;
        else if ($urandom_range(9) == 0) ev.lower_bound = rand_weight();
        case ($urandom_range(3))
            0: ev.particle_weight = ev.lower_bound - 32'($urandom_range(3));
            1: ev.particle_weight = ev.upper_bound * 32'($urandom_range(1, 80))
                                    + 32'($urandom_range(2));
            2: ev.particle_weight = rand_weight();
            default: ev.particle_weight = $urandom;
        endcase
        return ev;
    endfunction

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic make_event(logic [31:0] w, logic [31:0] lo, logic [31:0] up,
                              logic [31:0] tgt, logic [15:0] rnd);
        t_in ev;
        ev.particle_weight = w;
        ev.lower_bound = lo;
        ev.upper_bound = up;
        ev.target_weight = tgt;
        ev.random_value = rnd;
        send_event(ev);
    endtask

    task automatic test_directed();
        make_event(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h1234_5678, 16'h0);
        make_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        make_event(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
        make_event(32'h0000_4000, 32'h0001_0000, 32'h0002_0000, 32'hAAAA_5555, 16'h3FFF);
        make_event(32'h0000_4000, 32'h0001_0000, 32'h0002_0000, 32'h5555_AAAA, 16'h4000);
        make_event(32'h0000_4000, 32'h0001_0000, 32'h0002_0000, 32'h5555_AAAA, 16'hFFFF);
        make_event(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 16'd0);
        make_event(32'h0004_0001, 32'h0000_1000, 32'h0002_0000, 32'd0, 16'd0);
        make_event(32'h0004_0000, 32'h0000_1000, 32'h0002_0000, 32'd0, 16'd0);
        make_event(32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 16'd0);
        make_event(32'd65, 32'd0, 32'd1, 32'd0, 16'd0);
        make_event(32'd64, 32'd0, 32'd1, 32'd0, 16'd0);
        make_event(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE, 32'd0, 16'd0);
        // Inverted window: below lower and above upper still plays roulette.
        make_event(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hDEAD_BEEF, 16'h0001);
        make_event(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hDEAD_BEEF, 16'hFFFF);
        make_event(32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'd7, 16'd0);
        make_event(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'd7, 16'd0);
        make_event(32'h1234_5678, 32'hFFFF_FFFF, 32'd0, 32'h0F0F_0F0F, 16'h8000);
        idle_input();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_event(rand_event());
        idle_input();
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(225, 0, 0);
        // Let the pipeline empty completely before resuming.
        wait_drained();
        test_random(225, 47, 0);
        test_random(225, 0, 47);
        test_random(225, 28, 28);
        recv_stall_pct = 0;
        wait_drained();
        repeat (Latency) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// File: weight_window_roulette_split.f
+incdir+rtl
rtl/wwrs_pkg.sv
rtl/wwrs_in_if.sv
rtl/wwrs_out_if.sv
rtl/wwrs_div.sv
rtl/weight_window_roulette_split.sv
sim/tb_top.sv
